// ----- rtl/spoe_pkg.sv -----
package spoe_pkg;

  // Operation codes carried in the op field of an input word.
  localparam logic [2:0] OP_ADDR_WR    = 3'd0;
  localparam logic [2:0] OP_DATA_WR    = 3'd1;
  localparam logic [2:0] OP_CLEAR      = 3'd2;
  localparam logic [2:0] OP_EVAL       = 3'd3;
  localparam logic [2:0] OP_CLR_STATUS = 3'd4;

  localparam logic [8:0] EVAL_START_DOT = 9'd65;
  localparam logic [8:0] SPRITE0_DOT    = 9'd66;
  localparam logic [8:0] CLEAR_START_DOT = 9'd1;
  localparam logic [1:0] COPY_REST      = 2'd3;
  localparam logic [7:0] FILL_BYTE      = 8'hFF;

  localparam int         CFG_AW          = 2;
  localparam logic [1:0] CFG_ADDR_HEIGHT = 2'd0;
  localparam logic [4:0] HEIGHT_RESET    = 5'd8;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] cpu_data;
    logic [8:0] scanline;
    logic [8:0] dot;
  } in_word_t;

  typedef struct packed {
    logic [7:0] oam_read_data;
    logic       overflow_flag;
    logic       sprite0_next_line;
    logic       sec_write_valid;
    logic [4:0] sec_write_addr;
    logic [7:0] sec_write_data;
  } out_word_t;

  // Where the current latched byte lives: in a register, or still in the
  // registered read data of one of the two tables.
  typedef enum logic [1:0] {
    LB_REG,
    LB_PRI,
    LB_SEC
  } lb_src_t;

  typedef struct packed {
    out_word_t word;
    lb_src_t   src;
  } stage_t;

  function automatic logic [7:0] lb_pick(input lb_src_t src, input logic [7:0] held,
                                         input logic [7:0] pri, input logic [7:0] sec);
    logic [7:0] v;
    v = held;
    case (src)
      LB_PRI:  v = pri;
      LB_SEC:  v = sec;
      default: v = held;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/spoe_table.sv -----
module spoe_table
  import spoe_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [7:0]       rdata_r;
  logic             rvalid_r;

  // An entry never written since reset reads as the fill byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r  <= mem[raddr];
      rvalid_r <= valid_r[raddr];
    end
  end

  assign rdata = rvalid_r ? rdata_r : FILL_BYTE;

endmodule

// ----- rtl/spoe_core.sv -----
module spoe_core
  import spoe_pkg::*;
#(
  parameter int PRIMARY_BYTES   = 256,
  parameter int SECONDARY_BYTES = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               accept,
  input  in_word_t                           in_word,
  input  logic [4:0]                         height,
  input  logic [7:0]                         pri_rdata,
  input  logic [7:0]                         sec_rdata,
  output logic                               pri_we,
  output logic [$clog2(PRIMARY_BYTES)-1:0]   pri_waddr,
  output logic [7:0]                         pri_wdata,
  output logic                               pri_re,
  output logic [$clog2(PRIMARY_BYTES)-1:0]   pri_raddr,
  output logic                               sec_we,
  output logic [$clog2(SECONDARY_BYTES)-1:0] sec_waddr,
  output logic [7:0]                         sec_wdata,
  output logic                               sec_re,
  output logic [$clog2(SECONDARY_BYTES)-1:0] sec_raddr,
  output stage_t                             result
);

  localparam int PIW = $clog2(PRIMARY_BYTES);
  localparam int SIW = $clog2(SECONDARY_BYTES);

  logic [PIW-1:0] pidx_r, pidx_nxt;
  logic [SIW-1:0] sidx_r, sidx_nxt;
  logic [7:0]     latched_r, latched_nxt;
  lb_src_t        lb_src_r, lb_src_nxt;
  logic           pwrap_r, pwrap_nxt;
  logic           swrap_r, swrap_nxt;
  logic           osearch_r, osearch_nxt;
  logic           ostatus_r, ostatus_nxt;
  logic           s0_r, s0_nxt;
  logic [1:0]     copy_r, copy_nxt;

  logic [7:0]     lb_eff;
  logic [7:0]     y;
  logic [8:0]     diff;
  logic           hit;
  logic           full;
  logic [8:0]     amod;
  logic [PIW:0]   step_sum;
  logic [PIW:0]   jump;
  logic [1:0]     diag_lo;
  logic           wv;
  logic [SIW-1:0] wa;
  logic [SIW+4:0] wa_wide;
  logic [7:0]     wd;

  function automatic logic [PIW-1:0] pinc(input logic [PIW-1:0] x);
    return (x == PIW'(PRIMARY_BYTES - 1)) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [SIW-1:0] sinc(input logic [SIW-1:0] x);
    return (x == SIW'(SECONDARY_BYTES - 1)) ? '0 : x + 1'b1;
  endfunction

  assign lb_eff = lb_pick(lb_src_r, latched_r, pri_rdata, sec_rdata);

  always_comb begin
    pidx_nxt    = pidx_r;
    sidx_nxt    = sidx_r;
    latched_nxt = lb_eff;
    lb_src_nxt  = LB_REG;
    pwrap_nxt   = pwrap_r;
    swrap_nxt   = swrap_r;
    osearch_nxt = osearch_r;
    ostatus_nxt = ostatus_r;
    s0_nxt      = s0_r;
    copy_nxt    = copy_r;
    pri_we      = 1'b0;
    pri_waddr   = pidx_r;
    pri_wdata   = in_word.cpu_data;
    pri_re      = 1'b0;
    pri_raddr   = pidx_r;
    sec_we      = 1'b0;
    sec_re      = 1'b0;
    sec_raddr   = sidx_r;
    wv          = 1'b0;
    wa          = '0;
    wd          = '0;
    y           = lb_eff;
    diff        = in_word.scanline - {1'b0, y};
    hit         = (in_word.scanline >= {1'b0, y}) && (diff < {4'b0, height});
    full        = 1'b0;
    amod        = {1'b0, in_word.cpu_data};
    step_sum    = '0;
    jump        = '0;
    diag_lo     = '0;

    case (in_word.op)
      OP_ADDR_WR: begin
        for (int k = 0; k < 4; k++) begin
          if (amod >= 9'(PRIMARY_BYTES)) begin
            amod = amod - 9'(PRIMARY_BYTES);
          end
        end
        pidx_nxt = amod[PIW-1:0];
      end
      OP_DATA_WR: begin
        latched_nxt = in_word.cpu_data;
        pri_we      = 1'b1;
        pidx_nxt    = pinc(pidx_r);
      end
      OP_CLEAR: begin
        if (in_word.dot == CLEAR_START_DOT) begin
          sidx_nxt = '0;
        end
        if (!in_word.dot[0]) begin
          wv       = 1'b1;
          wa       = sidx_nxt;
          wd       = FILL_BYTE;
          sec_we   = 1'b1;
          sidx_nxt = sinc(sidx_nxt);
        end
      end
      OP_EVAL: begin
        if (in_word.dot == EVAL_START_DOT) begin
          pwrap_nxt   = 1'b0;
          swrap_nxt   = 1'b0;
          ostatus_nxt = 1'b0;
          osearch_nxt = 1'b0;
          copy_nxt    = '0;
          sidx_nxt    = '0;
        end
        if (in_word.dot[0]) begin
          pri_re     = 1'b1;
          lb_src_nxt = LB_PRI;
        end else begin
          full = pwrap_nxt || swrap_nxt;
          if (!full) begin
            wv     = 1'b1;
            wa     = sidx_nxt;
            wd     = y;
            sec_we = 1'b1;
          end else begin
            sec_re     = 1'b1;
            sec_raddr  = sidx_nxt;
            lb_src_nxt = LB_SEC;
          end
          if (copy_nxt != 2'd0 || (hit && !full)) begin
            // Copy the rest of a sprite, or start copying an in-range one.
            if (copy_nxt != 2'd0) begin
              copy_nxt = copy_nxt - 2'd1;
            end else begin
              copy_nxt = COPY_REST;
              if (in_word.dot == SPRITE0_DOT) begin
                s0_nxt = hit;
              end
            end
            pidx_nxt    = pinc(pidx_r);
            sidx_nxt    = sinc(sidx_nxt);
            if (pidx_nxt == '0) begin
              pwrap_nxt = 1'b1;
            end
            osearch_nxt = 1'b0;
            if (sidx_nxt == '0) begin
              swrap_nxt   = 1'b1;
              osearch_nxt = 1'b1;
            end
          end else begin
            if (in_word.dot == SPRITE0_DOT) begin
              s0_nxt = hit;
            end
            step_sum = {1'b0, pidx_r} + (PIW+1)'(4);
            diag_lo  = pidx_r[1:0] + 2'd1;
            if (!osearch_nxt) begin
              jump = {step_sum[PIW:2], 2'b00};
              if (jump >= (PIW+1)'(PRIMARY_BYTES)) begin
                jump = jump - (PIW+1)'(PRIMARY_BYTES);
              end
              pidx_nxt = jump[PIW-1:0];
              if (pidx_nxt == '0) begin
                pwrap_nxt = 1'b1;
              end
            end else if (hit && !pwrap_nxt) begin
              ostatus_nxt = 1'b1;
              osearch_nxt = 1'b0;
            end else begin
              // Hardware quirk: the byte offset advances along with the sprite.
              jump = {step_sum[PIW:2], diag_lo};
              if (jump >= (PIW+1)'(PRIMARY_BYTES)) begin
                jump = jump - (PIW+1)'(PRIMARY_BYTES);
              end
              pidx_nxt = jump[PIW-1:0];
              if (pidx_nxt[PIW-1:2] == '0) begin
                pwrap_nxt = 1'b1;
              end
            end
          end
        end
      end
      OP_CLR_STATUS: begin
        ostatus_nxt = 1'b0;
        s0_nxt      = 1'b0;
      end
      default: begin
      end
    endcase

    if (!accept) begin
      pri_we = 1'b0;
      pri_re = 1'b0;
      sec_we = 1'b0;
      sec_re = 1'b0;
    end
  end

  assign sec_waddr = wa;
  assign sec_wdata = wd;
  assign wa_wide   = {5'b0, wa};

  always_comb begin
    result.word.oam_read_data     = latched_nxt;
    result.word.overflow_flag     = ostatus_nxt;
    result.word.sprite0_next_line = s0_nxt;
    result.word.sec_write_valid   = wv;
    result.word.sec_write_addr    = wa_wide[4:0];
    result.word.sec_write_data    = wd;
    result.src                    = lb_src_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pidx_r    <= '0;
      sidx_r    <= '0;
      latched_r <= '0;
      lb_src_r  <= LB_REG;
      pwrap_r   <= 1'b0;
      swrap_r   <= 1'b0;
      osearch_r <= 1'b0;
      ostatus_r <= 1'b0;
      s0_r      <= 1'b0;
      copy_r    <= '0;
    end else if (accept) begin
      pidx_r    <= pidx_nxt;
      sidx_r    <= sidx_nxt;
      latched_r <= latched_nxt;
      lb_src_r  <= lb_src_nxt;
      pwrap_r   <= pwrap_nxt;
      swrap_r   <= swrap_nxt;
      osearch_r <= osearch_nxt;
      ostatus_r <= ostatus_nxt;
      s0_r      <= s0_nxt;
      copy_r    <= copy_nxt;
    end
  end

  a_sec_rw_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(sec_we && sec_re))
    else $error("secondary table read and written by one word");

  a_odd_read: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_word.op == OP_EVAL && in_word.dot[0] |=> lb_src_r == LB_PRI)
    else $error("odd evaluation dot did not take its byte from the primary table");

  a_eval_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_word.op == OP_EVAL && in_word.dot == EVAL_START_DOT
    |=> !pwrap_r && !swrap_r && !ostatus_r && copy_r == 2'd0)
    else $error("evaluation start did not clear the scan state");

endmodule

// ----- rtl/sprite_oam_evaluation.sv -----
// Channel   Direction  Handshake               Word
// in_*      input      in_valid / in_stall     in_word_t: op, cpu_data, scanline, dot
// out_*     output     out_valid / out_stall   out_word_t: latched byte, flags, secondary write
// APB       input      psel/penable/pready     sprite_height at byte address 0
//
// One word is accepted every cycle while not stalled; its result goes via s2_r and then out_r.
// The rate is set by the read-modify-write of the scan state around the two tables,
// each read through one registered port.
// Reset clears all control state and the per-entry valid bits of both tables at once;
// unwritten entries read as 0xFF, so no clearing pass follows reset.
// A stalled output holds its word; in_stall needs both result stages full and out_stall high.
module sprite_oam_evaluation
  import spoe_pkg::*;
#(
  parameter int PRIMARY_BYTES   = 256,
  parameter int SECONDARY_BYTES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_word,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int PIW = $clog2(PRIMARY_BYTES);
  localparam int SIW = $clog2(SECONDARY_BYTES);

  logic [4:0]     height_r;
  logic           accept;
  logic           out_free;
  logic           s2_free;
  logic           s2_v_r;
  stage_t         s2_r;
  logic           out_v_r;
  out_word_t      out_r;
  out_word_t      out_fwd;
  stage_t         s1_result;

  logic           pri_we, pri_re;
  logic [PIW-1:0] pri_waddr, pri_raddr;
  logic [7:0]     pri_wdata, pri_rdata;
  logic           sec_we, sec_re;
  logic [SIW-1:0] sec_waddr, sec_raddr;
  logic [7:0]     sec_wdata, sec_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr == CFG_ADDR_HEIGHT) ? {27'b0, height_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= HEIGHT_RESET;
    end else if (psel && penable && pwrite && pready && paddr == CFG_ADDR_HEIGHT) begin
      height_r <= pwdata[4:0];
    end
  end

  assign out_free = !out_v_r || !out_stall;
  assign s2_free  = !s2_v_r || out_free;
  assign in_stall = !s2_free;
  assign accept   = in_valid && s2_free;

  spoe_core #(
    .PRIMARY_BYTES  (PRIMARY_BYTES),
    .SECONDARY_BYTES(SECONDARY_BYTES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_word  (in_word),
    .height   (height_r),
    .pri_rdata(pri_rdata),
    .sec_rdata(sec_rdata),
    .pri_we   (pri_we),
    .pri_waddr(pri_waddr),
    .pri_wdata(pri_wdata),
    .pri_re   (pri_re),
    .pri_raddr(pri_raddr),
    .sec_we   (sec_we),
    .sec_waddr(sec_waddr),
    .sec_wdata(sec_wdata),
    .sec_re   (sec_re),
    .sec_raddr(sec_raddr),
    .result   (s1_result)
  );

  spoe_table #(
    .DEPTH(PRIMARY_BYTES),
    .AW   (PIW)
  ) u_primary (
    .clk  (clk),
    .rst_n(rst_n),
    .we   (pri_we),
    .waddr(pri_waddr),
    .wdata(pri_wdata),
    .re   (pri_re),
    .raddr(pri_raddr),
    .rdata(pri_rdata)
  );

  spoe_table #(
    .DEPTH(SECONDARY_BYTES),
    .AW   (SIW)
  ) u_secondary (
    .clk  (clk),
    .rst_n(rst_n),
    .we   (sec_we),
    .waddr(sec_waddr),
    .wdata(sec_wdata),
    .re   (sec_re),
    .raddr(sec_raddr),
    .rdata(sec_rdata)
  );

  // The table read data stays put until the next word is accepted, which is no
  // earlier than the edge at which this stage hands its word on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (accept) begin
        s2_v_r <= 1'b1;
      end else if (out_free) begin
        s2_v_r <= 1'b0;
      end
      if (out_free) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_comb begin
    out_fwd               = s2_r.word;
    out_fwd.oam_read_data = lb_pick(s2_r.src, s2_r.word.oam_read_data, pri_rdata, sec_rdata);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_r <= s1_result;
    end
    if (out_free && s2_v_r) begin
      out_r <= out_fwd;
    end
  end

  assign out_valid = out_v_r;
  assign out_word  = out_r;

  a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(s2_v_r))
    else $error("output word appeared without a word in the middle stage");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s2_v_r && out_v_r && out_stall)
    else $error("input stalled while the pipeline had room");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && !out_free |=> s2_v_r && $stable(s2_r))
    else $error("middle stage lost its word while the output was blocked");

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import spoe_pkg::*;

  localparam int PRI_BYTES    = 256;
  localparam int SEC_BYTES    = 32;
  localparam int SPRITE_BYTES = 4;
  localparam int LAST_LINE    = 261;
  localparam int LAST_DOT     = 340;

  // Op codes the block does not decode.
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_word_t          in_word   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_word_t         out_word;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [CFG_AW-1:0] paddr     = '0;
  logic [31:0]       pwdata    = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Predicted state of the sprite evaluation unit.
  logic [7:0] pri_oam [PRI_BYTES];
  logic [7:0] sec_oam [SEC_BYTES];
  logic [7:0] pri_idx;
  logic [4:0] sec_idx;
  logic [7:0] latch_q;
  logic       pri_wrap;
  logic       sec_wrap;
  logic       ovf_hunt;
  logic       ovf_flag;
  logic       spr0_flag;
  logic [1:0] copy_left;
  logic [4:0] spr_height;

  out_word_t expected_words[$];
  int        n_errors       = 0;
  int        words_sent     = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;

  sprite_oam_evaluation #(
    .PRIMARY_BYTES  (PRI_BYTES),
    .SECONDARY_BYTES(SEC_BYTES)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

  function automatic void reset_sprite_state();
    foreach (pri_oam[i]) pri_oam[i] = FILL_BYTE;
    foreach (sec_oam[i]) sec_oam[i] = FILL_BYTE;
    pri_idx    = '0;
    sec_idx    = '0;
    latch_q    = '0;
    pri_wrap   = 1'b0;
    sec_wrap   = 1'b0;
    ovf_hunt   = 1'b0;
    ovf_flag   = 1'b0;
    spr0_flag  = 1'b0;
    copy_left  = '0;
    spr_height = HEIGHT_RESET;
  endfunction

  function automatic void step_both_indices();
    pri_idx = pri_idx + 8'd1;
    sec_idx = sec_idx + 5'd1;
    if (pri_idx == '0) pri_wrap = 1'b1;
    ovf_hunt = 1'b0;
    if (sec_idx == '0) begin
      sec_wrap = 1'b1;
      ovf_hunt = 1'b1;
    end
  endfunction

  function automatic out_word_t predict_sprite_word(in_word_t w);
    out_word_t  r;
    logic [7:0] y;
    logic       hit;
    int         diff;
    r = '0;
    case (w.op)
      OP_ADDR_WR: pri_idx = w.cpu_data;
      OP_DATA_WR: begin
        latch_q = w.cpu_data;
        pri_oam[pri_idx] = w.cpu_data;
        pri_idx = pri_idx + 8'd1;
      end
      OP_CLEAR: begin
        if (w.dot == CLEAR_START_DOT) sec_idx = '0;
        if (!w.dot[0]) begin
          sec_oam[sec_idx] = FILL_BYTE;
          r.sec_write_valid = 1'b1;
          r.sec_write_addr  = sec_idx;
          r.sec_write_data  = FILL_BYTE;
          sec_idx = sec_idx + 5'd1;
        end
      end
      OP_EVAL: begin
        if (w.dot == EVAL_START_DOT) begin
          pri_wrap  = 1'b0;
          sec_wrap  = 1'b0;
          ovf_flag  = 1'b0;
          ovf_hunt  = 1'b0;
          copy_left = '0;
          sec_idx   = '0;
        end
        if (w.dot[0]) begin
          latch_q = pri_oam[pri_idx];
        end else begin
          y = latch_q;
          // Once either table has wrapped, even dots read back instead of writing.
          if (!(pri_wrap || sec_wrap)) begin
            sec_oam[sec_idx] = latch_q;
            r.sec_write_valid = 1'b1;
            r.sec_write_addr  = sec_idx;
            r.sec_write_data  = latch_q;
          end else begin
            latch_q = sec_oam[sec_idx];
          end
          if (copy_left != '0) begin
            copy_left = copy_left - 2'd1;
            step_both_indices();
          end else begin
            diff = int'(w.scanline) - int'(y);
            hit  = (diff >= 0) && (diff < int'(spr_height));
            if (w.dot == SPRITE0_DOT) spr0_flag = hit;
            if (hit && !(pri_wrap || sec_wrap)) begin
              copy_left = COPY_REST;
              step_both_indices();
            end else if (!ovf_hunt) begin
              pri_idx = {pri_idx[7:2] + 6'd1, 2'b00};
              if (pri_idx == '0) pri_wrap = 1'b1;
            end else if (hit && !pri_wrap) begin
              ovf_flag = 1'b1;
              ovf_hunt = 1'b0;
            end else begin
              // The hardware bug: the byte offset advances along with the sprite.
              pri_idx = {pri_idx[7:2] + 6'd1, pri_idx[1:0] + 2'd1};
              if (pri_idx[7:2] == '0) pri_wrap = 1'b1;
            end
          end
        end
      end
      OP_CLR_STATUS: begin
        ovf_flag  = 1'b0;
        spr0_flag = 1'b0;
      end
      default: ;
    endcase
    r.oam_read_data     = latch_q;
    r.overflow_flag     = ovf_flag;
    r.sprite0_next_line = spr0_flag;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("result word 0x%0h arrived with nothing expected", out_word);
        n_errors++;
      end else begin
        want = expected_words.pop_front();
        check_field("oam_read_data", want.oam_read_data, out_word.oam_read_data);
        check_field("overflow_flag", 8'(want.overflow_flag), 8'(out_word.overflow_flag));
        check_field("sprite0_next_line", 8'(want.sprite0_next_line),
                    8'(out_word.sprite0_next_line));
        check_field("sec_write_valid", 8'(want.sec_write_valid),
                    8'(out_word.sec_write_valid));
        check_field("sec_write_addr", 8'(want.sec_write_addr), 8'(out_word.sec_write_addr));
        check_field("sec_write_data", want.sec_write_data, out_word.sec_write_data);
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic in_word_t mk_word(logic [2:0] op, int data, int line, int dot);
    in_word_t w;
    w.op       = op;
    w.cpu_data = 8'(data);
    w.scanline = 9'(line);
    w.dot      = 9'(dot);
    return w;
  endfunction

  function automatic in_word_t random_word();
    return mk_word(3'($urandom_range(7)), $urandom_range(255),
                   $urandom_range(LAST_LINE), $urandom_range(LAST_DOT));
  endfunction

  // Called and returns at a falling edge.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_words.push_back(predict_sprite_word(w));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_sprite_height(input logic [4:0] h);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_HEIGHT;
    pwdata  <= 32'(h);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    spr_height = h;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[4:0] !== h) begin
      $error("sprite_height: expected 0x%0h, got 0x%0h", h, prdata[4:0]);
      n_errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly whole lines: upload a few sprites with Y near the line, clear part or all of
  // the secondary table, then run evaluation dots from the start dot onward.
  task automatic run_sprite_lines(input int n_words);
    int         stop_at;
    int         line;
    int         n_spr;
    int         n_clr;
    int         n_eval;
    int         y;
    logic [7:0] base;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      if ($urandom_range(9) < 3) begin
        repeat ($urandom_range(10, 1)) send_word(random_word());
      end else begin
        line  = $urandom_range(LAST_LINE);
        n_spr = $urandom_range(12, 4);
        base  = ($urandom_range(3) == 0) ? 8'($urandom_range(63) * SPRITE_BYTES) : 8'h00;
        send_word(mk_word(OP_ADDR_WR, base, $urandom_range(LAST_LINE),
                          $urandom_range(LAST_DOT)));
        for (int s = 0; s < n_spr && words_sent < stop_at; s++) begin
          y = line - int'($urandom_range(int'(spr_height) + 2));
          if ($urandom_range(3) == 0 || y < 0 || y > 255) y = $urandom_range(255);
          send_word(mk_word(OP_DATA_WR, y, $urandom_range(LAST_LINE),
                            $urandom_range(LAST_DOT)));
          for (int b = 1; b < SPRITE_BYTES; b++)
            send_word(mk_word(OP_DATA_WR, $urandom_range(255), $urandom_range(LAST_LINE),
                              $urandom_range(LAST_DOT)));
        end
        n_clr = ($urandom_range(5) == 0) ? 64 : $urandom_range(8);
        for (int d = 1; d <= n_clr && words_sent < stop_at; d++)
          send_word(mk_word(OP_CLEAR, $urandom_range(255), line, d));
        send_word(mk_word(OP_ADDR_WR, base, line, $urandom_range(LAST_DOT)));
        n_eval = ($urandom_range(3) == 0) ? 96 : $urandom_range(48, 12);
        for (int d = 0; d < 2 * n_eval && words_sent < stop_at; d++)
          send_word(mk_word(OP_EVAL, $urandom_range(255), line, EVAL_START_DOT + d));
      end
    end
  endtask

  task automatic test_directed_corners();
    send_word(mk_word(OP_ADDR_WR, 8'h00, 0, 0));
    // Sprite 0 sits at Y 0 so it is on line 7 with the default height.
    send_word(mk_word(OP_DATA_WR, 8'h00, LAST_LINE, LAST_DOT));
    send_word(mk_word(OP_DATA_WR, 8'hFF, 0, 0));
    send_word(mk_word(OP_DATA_WR, 8'hA5, 0, 0));
    send_word(mk_word(OP_DATA_WR, 8'h5A, 0, 0));
    send_word(mk_word(OP_CLEAR, 8'hFF, 0, CLEAR_START_DOT));
    send_word(mk_word(OP_CLEAR, 8'h00, 0, CLEAR_START_DOT + 1));
    send_word(mk_word(OP_ADDR_WR, 8'h00, 0, 0));
    for (int d = 0; d < 2 * SPRITE_BYTES; d++)
      send_word(mk_word(OP_EVAL, 8'h00, 7, EVAL_START_DOT + d));
    send_word(mk_word(OP_CLR_STATUS, 8'hFF, LAST_LINE, LAST_DOT));
    send_word(mk_word(OP_SPARE_5, 8'hFF, LAST_LINE, LAST_DOT));
    send_word(mk_word(OP_SPARE_6, 8'h00, 0, 0));
    send_word(mk_word(OP_SPARE_7, 8'hFF, LAST_LINE, LAST_DOT));
    // The data port index wraps from the last byte back to zero.
    send_word(mk_word(OP_ADDR_WR, 8'hFF, 0, 0));
    send_word(mk_word(OP_DATA_WR, 8'h42, 0, 0));
    send_word(mk_word(OP_DATA_WR, 8'hF0, 0, 0));
    send_word(mk_word(OP_EVAL, 8'hFF, LAST_LINE, LAST_DOT));
  endtask

  task automatic test_tall_sprites();
    drain_results();
    write_sprite_height(5'd16);
    run_sprite_lines(150);
  endtask

  task automatic test_odd_height();
    drain_results();
    write_sprite_height(5'd31);
    run_sprite_lines(150);
  endtask

  task automatic test_height_extremes();
    drain_results();
    write_sprite_height(5'd0);
    run_sprite_lines(30);
    drain_results();
    write_sprite_height(HEIGHT_RESET);
    run_sprite_lines(120);
  endtask

  initial begin
    reset_sprite_state();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct  = 19;
    recv_stall_pct = 47;
    test_directed_corners();
    test_tall_sprites();
    send_idle_pct  = 47;
    recv_stall_pct = 19;
    test_odd_height();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_height_extremes();
    drain_results();
    if (n_errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
